FILE: src/uer_pkg.sv
package uer_pkg;

    // default width of the echo tick counter
    localparam int COUNT_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INCH  = 3'd4;

    // register reset values
    localparam logic [7:0]  TRIG_LOW_RST  = 8'd3;
    localparam logic [7:0]  TRIG_HIGH_RST = 8'd13;
    localparam logic [17:0] HOLDOFF_RST   = 18'd250000;
    localparam logic [9:0]  MAX_CM_RST    = 10'd400;
    localparam logic [8:0]  MAX_INCH_RST  = 9'd157;

    // conversion constants: every 10 ticks add 8 us, 58 us per cm, 148 us per inch
    localparam int TICKS_PER_STEP = 10;
    localparam int US_PER_STEP    = 8;
    localparam int US_PER_CM      = 58;
    localparam int US_PER_INCH    = 148;

    localparam int CM_W   = 10;
    localparam int INCH_W = 9;
    localparam int BCD_W  = 12;

    // control from the phase sequencer to the distance tracker
    typedef struct packed {
        logic start;
        logic step;
    } trk_ctl_t;

    // running distance values
    typedef struct packed {
        logic [CM_W-1:0]   cm;
        logic [INCH_W-1:0] inch;
        logic [BCD_W-1:0]  cm_bcd;
        logic [BCD_W-1:0]  inch_bcd;
    } dist_t;

endpackage

FILE: src/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger: one input word per count-clock tick carries the sampled echo
// level, and each accepted word yields exactly one output word in the next cycle with
// the trigger level for that tick and, on the tick where the echo falls, the distance
// in cm and inches with their bcd digits (tuser high marks such a word). A word is
// taken every cycle; the only limit is the single output register, which is reloaded
// in the cycle it is read. The distances are not divided at the falling edge: small
// quotient and remainder counters advance with the echo tick count, so the result is
// ready the moment the echo ends. Configuration writes are meant for idle periods.
module ultrasonic_echo_ranger_unit #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input word
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] echo_level
    // output word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] trigger_level, [1] in_range, [11:2] range_cm, [20:12] distance_inch,
    // [32:21] cm_digits, [44:33] inch_digits
    output logic [47:0]                      m_tdata,
    output logic                             m_tuser,   // [0] result_valid
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        PH_TRIG_LOW  = 4'b0001,
        PH_TRIG_HIGH = 4'b0010,
        PH_MEASURE   = 4'b0100,
        PH_HOLDOFF   = 4'b1000
    } phase_t;

    localparam int TMR_W = 18;

    phase_t             phase_reg, phase_next;
    logic [TMR_W-1:0]   timer_reg, timer_next, timer_inc;
    logic               echo_prev_reg;
    logic [7:0]         trig_low_reg, trig_high_reg;
    logic [17:0]        holdoff_reg;
    logic [9:0]         max_cm_reg;
    logic [8:0]         max_inch_reg;
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;
    logic               out_user_reg;

    logic               accept;
    logic               echo;
    logic               trig;
    logic               res_valid;
    logic               in_range;
    uer_pkg::trk_ctl_t  ctl, trk_ctl;
    uer_pkg::dist_t     meas;
    logic [47:0]        data_next;

    assign accept    = s_tvalid && s_tready;
    assign echo      = s_tdata[0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign timer_inc = timer_reg + TMR_W'(1);
    assign in_range  = (meas.cm < max_cm_reg) && (meas.inch < max_inch_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_low_reg  <= uer_pkg::TRIG_LOW_RST;
            trig_high_reg <= uer_pkg::TRIG_HIGH_RST;
            holdoff_reg   <= uer_pkg::HOLDOFF_RST;
            max_cm_reg    <= uer_pkg::MAX_CM_RST;
            max_inch_reg  <= uer_pkg::MAX_INCH_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == uer_pkg::REG_TRIG_LOW) begin
                trig_low_reg <= cfg_wdata[7:0];
            end
            if (cfg_index == uer_pkg::REG_TRIG_HIGH) begin
                trig_high_reg <= cfg_wdata[7:0];
            end
            if (cfg_index == uer_pkg::REG_HOLDOFF) begin
                holdoff_reg <= cfg_wdata[17:0];
            end
            if (cfg_index == uer_pkg::REG_MAX_CM) begin
                max_cm_reg <= cfg_wdata[9:0];
            end
            if (cfg_index == uer_pkg::REG_MAX_INCH) begin
                max_inch_reg <= cfg_wdata[8:0];
            end
        end
    end

    // phase sequencer
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        trig       = 1'b0;
        res_valid  = 1'b0;
        ctl        = '0;
        unique case (phase_reg)
            PH_MEASURE: begin
                if (echo) begin
                    ctl.step = 1'b1;
                end else begin
                    res_valid  = 1'b1;
                    timer_next = '0;
                    if (in_range && (holdoff_reg != '0)) begin
                        phase_next = PH_HOLDOFF;
                    end else begin
                        phase_next = PH_TRIG_LOW;
                    end
                end
            end
            PH_HOLDOFF: begin
                timer_next = timer_inc;
                if (timer_inc >= holdoff_reg) begin
                    phase_next = PH_TRIG_LOW;
                    timer_next = '0;
                end
            end
            PH_TRIG_LOW, PH_TRIG_HIGH: begin
                if (echo) begin
                    timer_next = '0;
                    if (!echo_prev_reg) begin
                        phase_next = PH_MEASURE;
                        ctl.start  = 1'b1;
                    end else begin
                        phase_next = PH_TRIG_LOW;
                    end
                end else if (phase_reg == PH_TRIG_LOW) begin
                    timer_next = timer_inc;
                    if (timer_inc >= TMR_W'(trig_low_reg)) begin
                        phase_next = PH_TRIG_HIGH;
                        timer_next = '0;
                    end
                end else begin
                    trig       = 1'b1;
                    timer_next = timer_inc;
                    if (timer_inc >= TMR_W'(trig_high_reg)) begin
                        phase_next = PH_TRIG_LOW;
                        timer_next = '0;
                    end
                end
            end
            default: begin
                phase_next = PH_TRIG_LOW;
                timer_next = '0;
            end
        endcase
    end

    assign trk_ctl.start = ctl.start && accept;
    assign trk_ctl.step  = ctl.step && accept;

    uer_dist_tracker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (trk_ctl),
        .meas    (meas)
    );

    // output word packing, result fields zero unless the echo ended, bcd digits also zero out of range
    always_comb begin
        data_next     = '0;
        data_next[0]  = trig;
        if (res_valid) begin
            data_next[1]     = in_range;
            data_next[11:2]  = meas.cm;
            data_next[20:12] = meas.inch;
            if (in_range) begin
                data_next[32:21] = meas.cm_bcd;
                data_next[44:33] = meas.inch_bcd;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TRIG_LOW;
            timer_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            echo_prev_reg <= echo;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= data_next;
            out_user_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: src/uer_dist_tracker.sv
module uer_dist_tracker #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  uer_pkg::trk_ctl_t ctl,
    output uer_pkg::dist_t    meas
);

    localparam int R10_W  = $clog2(uer_pkg::TICKS_PER_STEP);
    localparam int RCM_W  = $clog2(uer_pkg::US_PER_CM);
    localparam int RIN_W  = $clog2(uer_pkg::US_PER_INCH);
    localparam int CM_W   = uer_pkg::CM_W;
    localparam int INCH_W = uer_pkg::INCH_W;
    localparam int BCD_W  = uer_pkg::BCD_W;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [R10_W-1:0]      r10_reg, r10_next;
    logic [RCM_W-1:0]      rcm_reg, rcm_next;
    logic [RIN_W-1:0]      rin_reg, rin_next;
    logic [CM_W-1:0]       cm_reg, cm_next;
    logic [INCH_W-1:0]     inch_reg, inch_next;
    logic [BCD_W-1:0]      cm_bcd_reg, cm_bcd_next;
    logic [BCD_W-1:0]      inch_bcd_reg, inch_bcd_next;
    logic [RCM_W:0]        rcm_sum;
    logic [RIN_W:0]        rin_sum;

    // three-digit bcd increment, holding at 999
    function automatic logic [11:0] bcd3_inc(input logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (v != 12'h999) begin
            if (v[3:0] != 4'd9) begin
                r[3:0] = v[3:0] + 4'd1;
            end else begin
                r[3:0] = 4'd0;
                if (v[7:4] != 4'd9) begin
                    r[7:4] = v[7:4] + 4'd1;
                end else begin
                    r[7:4] = 4'd0;
                    r[11:8] = v[11:8] + 4'd1;
                end
            end
        end
        return r;
    endfunction

    assign rcm_sum = {1'b0, rcm_reg} + (RCM_W+1)'(uer_pkg::US_PER_STEP);
    assign rin_sum = {1'b0, rin_reg} + (RIN_W+1)'(uer_pkg::US_PER_STEP);

    // quotients follow the tick count one step at a time, saturating at field width
    always_comb begin
        count_next    = count_reg;
        r10_next      = r10_reg;
        rcm_next      = rcm_reg;
        rin_next      = rin_reg;
        cm_next       = cm_reg;
        inch_next     = inch_reg;
        cm_bcd_next   = cm_bcd_reg;
        inch_bcd_next = inch_bcd_reg;
        if (ctl.start) begin
            count_next    = COUNT_BITS'(1);
            r10_next      = R10_W'(1);
            rcm_next      = '0;
            rin_next      = '0;
            cm_next       = '0;
            inch_next     = '0;
            cm_bcd_next   = '0;
            inch_bcd_next = '0;
        end else if (ctl.step && (count_reg != {COUNT_BITS{1'b1}})) begin
            count_next = count_reg + COUNT_BITS'(1);
            if (r10_reg == R10_W'(uer_pkg::TICKS_PER_STEP - 1)) begin
                r10_next = '0;
                // centimetre quotient
                if (rcm_sum >= (RCM_W+1)'(uer_pkg::US_PER_CM)) begin
                    rcm_next = RCM_W'(rcm_sum - (RCM_W+1)'(uer_pkg::US_PER_CM));
                    if (cm_reg != {CM_W{1'b1}}) begin
                        cm_next     = cm_reg + CM_W'(1);
                        cm_bcd_next = bcd3_inc(cm_bcd_reg);
                    end
                end else begin
                    rcm_next = RCM_W'(rcm_sum);
                end
                // inch quotient
                if (rin_sum >= (RIN_W+1)'(uer_pkg::US_PER_INCH)) begin
                    rin_next = RIN_W'(rin_sum - (RIN_W+1)'(uer_pkg::US_PER_INCH));
                    if (inch_reg != {INCH_W{1'b1}}) begin
                        inch_next     = inch_reg + INCH_W'(1);
                        inch_bcd_next = bcd3_inc(inch_bcd_reg);
                    end
                end else begin
                    rin_next = RIN_W'(rin_sum);
                end
            end else begin
                r10_next = r10_reg + R10_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            r10_reg      <= '0;
            rcm_reg      <= '0;
            rin_reg      <= '0;
            cm_reg       <= '0;
            inch_reg     <= '0;
            cm_bcd_reg   <= '0;
            inch_bcd_reg <= '0;
        end else begin
            count_reg    <= count_next;
            r10_reg      <= r10_next;
            rcm_reg      <= rcm_next;
            rin_reg      <= rin_next;
            cm_reg       <= cm_next;
            inch_reg     <= inch_next;
            cm_bcd_reg   <= cm_bcd_next;
            inch_bcd_reg <= inch_bcd_next;
        end
    end

    assign meas.cm       = cm_reg;
    assign meas.inch     = inch_reg;
    assign meas.cm_bcd   = cm_bcd_reg;
    assign meas.inch_bcd = inch_bcd_reg;

endmodule
